[hw/rtl/profile_setpoint_interpolator_unit_macros.svh]
// -----------------------------------------------------------------------------
// profile setpoint interpolator assertion macros
// concurrent checks on i_clk, disabled while i_rst_n is low
// -----------------------------------------------------------------------------
`ifndef PROFILE_SETPOINT_INTERPOLATOR_UNIT_MACROS_SVH
`define PROFILE_SETPOINT_INTERPOLATOR_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PSI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define PSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/psi_pkg.sv]
// -----------------------------------------------------------------------------
// psi_pkg
// field widths, command codes and register indexes of the setpoint interpolator
// -----------------------------------------------------------------------------
package psi_pkg;

    localparam int CMD_W  = 2;
    localparam int TIME_W = 12;
    localparam int TEMP_W = 9;
    localparam int PROD_W = TIME_W + TEMP_W;

    localparam int MUL_CNT_W = $clog2(TIME_W);
    localparam int DIV_CNT_W = $clog2(PROD_W);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TIME_W;

    typedef logic [CMD_W-1:0]     t_cmd;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cmd CMD_CLEAR  = 2'd0;
    localparam t_cmd CMD_APPEND = 2'd1;
    localparam t_cmd CMD_QUERY  = 2'd2;

    localparam t_cfg_idx CFG_MAX_TIME    = 1'd0;
    localparam t_cfg_idx CFG_MANUAL_TEMP = 1'd1;

    localparam logic [TIME_W-1:0] MAX_TIME_RST    = 12'd900;
    localparam logic [TEMP_W-1:0] MANUAL_TEMP_RST = 9'd50;

    // divider result handed back to the sequencer
    typedef struct packed {
        logic              done;
        logic [TEMP_W-1:0] quot;
        logic              rem_nz;
    } t_div_res;

endpackage

[hw/rtl/psi_in_if.sv]
// -----------------------------------------------------------------------------
// psi_in_if
// command channel: clear, append point or query setpoint
// -----------------------------------------------------------------------------
interface psi_in_if;
    logic                        valid;
    logic                        ready;
    logic [psi_pkg::CMD_W-1:0]   cmd;
    logic [psi_pkg::TIME_W-1:0]  time_s;
    logic [psi_pkg::TEMP_W-1:0]  temp_deg;

    modport source (output valid, output cmd, output time_s, output temp_deg, input ready);
    modport sink   (input valid, input cmd, input time_s, input temp_deg, output ready);
endinterface

[hw/rtl/psi_out_if.sv]
// -----------------------------------------------------------------------------
// psi_out_if
// result channel: setpoint and status flags
// -----------------------------------------------------------------------------
interface psi_out_if;
    logic                        valid;
    logic                        ready;
    logic [psi_pkg::TEMP_W-1:0]  setpoint;
    logic                        done_res;
    logic                        table_full;

    modport source (output valid, output setpoint, output done_res, output table_full,
                    input ready);
    modport sink   (input valid, input setpoint, input done_res, input table_full,
                    output ready);
endinterface

[hw/rtl/psi_mul.sv]
// -----------------------------------------------------------------------------
// psi_mul
// bit-serial shift-add multiplier, one multiplier bit per cycle
// -----------------------------------------------------------------------------
module psi_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [psi_pkg::TEMP_W-1:0]  i_mcand,
    input  logic [psi_pkg::TIME_W-1:0]  i_mplier,
    output logic                        o_done,
    output logic [psi_pkg::PROD_W-1:0]  o_prod
);
    localparam logic [psi_pkg::MUL_CNT_W-1:0] CNT_LAST =
        psi_pkg::MUL_CNT_W'(psi_pkg::TIME_W - 1);

    logic                           r_busy;
    logic                           r_done;
    logic [psi_pkg::MUL_CNT_W-1:0]  r_cnt;
    logic [psi_pkg::TEMP_W-1:0]     r_a;
    logic [psi_pkg::TEMP_W-1:0]     r_hi;
    logic [psi_pkg::TIME_W-1:0]     r_lo;
    logic [psi_pkg::TEMP_W:0]       n_sum;

    // add the multiplicand into the upper half when the low bit is set
    assign n_sum = r_lo[0] ? ({1'b0, r_hi} + {1'b0, r_a}) : {1'b0, r_hi};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_mcand;
            r_hi <= '0;
            r_lo <= i_mplier;
        end else if (r_busy) begin
            r_hi <= n_sum[psi_pkg::TEMP_W:1];
            r_lo <= {n_sum[0], r_lo[psi_pkg::TIME_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = {r_hi, r_lo};
endmodule

[hw/rtl/psi_div.sv]
// -----------------------------------------------------------------------------
// psi_div
// restoring divider, one quotient bit per cycle
// -----------------------------------------------------------------------------
module psi_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [psi_pkg::PROD_W-1:0]  i_dividend,
    input  logic [psi_pkg::TIME_W-1:0]  i_divisor,
    output psi_pkg::t_div_res           o_res
);
    localparam logic [psi_pkg::DIV_CNT_W-1:0] CNT_LAST =
        psi_pkg::DIV_CNT_W'(psi_pkg::PROD_W - 1);

    logic                           r_busy;
    logic                           r_done;
    logic [psi_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [psi_pkg::TIME_W-1:0]     r_den;
    logic [psi_pkg::TIME_W-1:0]     r_rem;
    logic [psi_pkg::PROD_W-1:0]     r_dvd;
    logic [psi_pkg::TIME_W:0]       n_trial;
    logic [psi_pkg::TIME_W:0]       n_diff;
    logic                           n_ge;

    // shift in the next dividend bit and try a subtract
    assign n_trial = {r_rem, r_dvd[psi_pkg::PROD_W-1]};
    assign n_diff  = n_trial - {1'b0, r_den};
    assign n_ge    = (n_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_divisor;
            r_rem <= '0;
            r_dvd <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[psi_pkg::TIME_W-1:0] : n_trial[psi_pkg::TIME_W-1:0];
            r_dvd <= {r_dvd[psi_pkg::PROD_W-2:0], n_ge};
        end
    end

    // quotient magnitude stays below the temperature span
    assign o_res.done   = r_done;
    assign o_res.quot   = r_dvd[psi_pkg::TEMP_W-1:0];
    assign o_res.rem_nz = |r_rem;
endmodule

[hw/rtl/profile_setpoint_interpolator_unit.sv]
// -----------------------------------------------------------------------------
// profile_setpoint_interpolator_unit
// temperature profile table with piecewise linear setpoint lookup
// -----------------------------------------------------------------------------
// usage:
//   i_in carries one command transaction: clear the table, append a point
//   (time_s, temp_deg) or query the setpoint at elapsed time time_s.
//   o_out returns exactly one transaction per command: setpoint and done_res
//   for a query, table_full for a rejected append, zeros otherwise.
//   the config port (i_cfg_we, i_cfg_idx, i_cfg_data) writes max_time and
//   manual_temperature; write it only while no command is in flight.
// sequencing:
//   clear, append and unused codes: result valid the cycle after acceptance.
//   query: the table memory is scanned one entry at a time, each entry in a
//   read step and a compare step, until the first later point; then the
//   bit-serial multiply and the bit-serial divide run. empty table or a query
//   past the last point skips the arithmetic. one command is worked on at a
//   time.
// reset:
//   synchronous active low; table emptied (count zero), registers back to
//   max_time 900 and manual_temperature 50, output slot empty.
// stall:
//   the result sits in an output register; a new command is taken while it
//   waits only once the slot frees, and a finished query holds until then.
// -----------------------------------------------------------------------------
`include "profile_setpoint_interpolator_unit_macros.svh"

module profile_setpoint_interpolator_unit #(
    parameter int MAX_POINTS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    psi_in_if.sink                          i_in,
    psi_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [psi_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [psi_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);

    localparam int TW = psi_pkg::TIME_W;
    localparam int PW = psi_pkg::TEMP_W;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_READ  = 6'b000010,
        S_CHECK = 6'b000100,
        S_MUL   = 6'b001000,
        S_DIV   = 6'b010000,
        S_FIN   = 6'b100000
    } t_state;

    t_state                 r_state;

    // configuration registers
    logic [TW-1:0]          r_max_time;
    logic [PW-1:0]          r_manual_temp;

    // point table
    logic [TW-1:0]          mem_time [MAX_POINTS];
    logic [PW-1:0]          mem_temp [MAX_POINTS];
    logic [TW-1:0]          r_rd_time;
    logic [PW-1:0]          r_rd_temp;
    logic [CW-1:0]          r_cnt;

    // query context
    logic [CW-1:0]          r_idx;
    logic [TW-1:0]          r_t;
    logic                   r_done_flag;
    logic [TW-1:0]          r_prev_time;
    logic [PW-1:0]          r_prev_temp;
    logic [TW-1:0]          r_den;
    logic                   r_neg;
    logic [PW-1:0]          r_result;

    // output slot
    logic                   r_out_valid;
    logic [PW-1:0]          r_out_setpoint;
    logic                   r_out_done;
    logic                   r_out_full;

    logic                   w_slot_free;
    logic                   w_accept;
    logic                   w_full;
    logic                   w_found;
    logic                   w_mul_start;
    logic                   w_mul_done;
    logic [psi_pkg::PROD_W-1:0] w_prod;
    logic [PW-1:0]          w_dy;
    logic [TW-1:0]          w_dt;
    logic                   w_fin_load;
    psi_pkg::t_div_res      w_div;

    assign w_slot_free = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && w_slot_free;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_full      = (r_cnt == CNT_MAX);

    // compare the entry just read against the query time
    assign w_found     = (r_rd_time > r_t);
    assign w_mul_start = (r_state == S_CHECK) && w_found;
    assign w_dy        = (r_rd_temp >= r_prev_temp) ? (r_rd_temp - r_prev_temp)
                                                    : (r_prev_temp - r_rd_temp);
    assign w_dt        = r_t - r_prev_time;
    assign w_fin_load  = (r_state == S_FIN) && w_slot_free;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_time    <= psi_pkg::MAX_TIME_RST;
            r_manual_temp <= psi_pkg::MANUAL_TEMP_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == psi_pkg::CFG_MAX_TIME) begin
                r_max_time <= i_cfg_data;
            end
            if (i_cfg_idx == psi_pkg::CFG_MANUAL_TEMP) begin
                r_manual_temp <= i_cfg_data[PW-1:0];
            end
        end
    end

    // table memory: one write port for appends, one registered read port for the scan
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_in.cmd == psi_pkg::CMD_APPEND) && !w_full) begin
            mem_time[r_cnt[AW-1:0]] <= i_in.time_s;
            mem_temp[r_cnt[AW-1:0]] <= i_in.temp_deg;
        end
        r_rd_time <= mem_time[r_idx[AW-1:0]];
        r_rd_temp <= mem_temp[r_idx[AW-1:0]];
    end

    // point count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_accept) begin
            if (i_in.cmd == psi_pkg::CMD_CLEAR) begin
                r_cnt <= '0;
            end else if ((i_in.cmd == psi_pkg::CMD_APPEND) && !w_full) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // query sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_in.cmd == psi_pkg::CMD_QUERY)) begin
                        r_state <= (r_cnt == '0) ? S_FIN : S_READ;
                    end
                end
                S_READ: begin
                    // ran off the end: hold the last temperature
                    r_state <= (r_idx == r_cnt) ? S_FIN : S_CHECK;
                end
                S_CHECK: begin
                    r_state <= w_found ? S_MUL : S_READ;
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // query datapath, no reset needed
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_t         <= i_in.time_s;
                    r_done_flag <= (i_in.time_s > r_max_time);
                    r_idx       <= '0;
                    r_prev_time <= '0;
                    r_prev_temp <= '0;
                    r_result    <= r_manual_temp;
                end
            end
            S_READ: begin
                r_result <= r_prev_temp;
            end
            S_CHECK: begin
                if (w_found) begin
                    r_den <= r_rd_time - r_prev_time;
                    r_neg <= (r_rd_temp < r_prev_temp);
                end else begin
                    r_prev_time <= r_rd_time;
                    r_prev_temp <= r_rd_temp;
                    r_idx       <= r_idx + 1'b1;
                end
            end
            S_DIV: begin
                // falling segment floors toward minus infinity
                if (w_div.done) begin
                    r_result <= r_neg ? (r_prev_temp - w_div.quot - PW'(w_div.rem_nz))
                                      : (r_prev_temp + w_div.quot);
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((w_accept && (i_in.cmd != psi_pkg::CMD_QUERY)) || w_fin_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_load) begin
            r_out_setpoint <= r_result;
            r_out_done     <= r_done_flag;
            r_out_full     <= 1'b0;
        end else if (w_accept && (i_in.cmd != psi_pkg::CMD_QUERY)) begin
            r_out_setpoint <= '0;
            r_out_done     <= 1'b0;
            r_out_full     <= (i_in.cmd == psi_pkg::CMD_APPEND) && w_full;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.setpoint   = r_out_setpoint;
    assign o_out.done_res   = r_out_done;
    assign o_out.table_full = r_out_full;

    // |dy| * (t - x1), then divided by (x2 - x1)
    psi_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_mcand  (w_dy),
        .i_mplier (w_dt),
        .o_done   (w_mul_done),
        .o_prod   (w_prod)
    );

    psi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    ((r_state == S_MUL) && w_mul_done),
        .i_dividend (w_prod),
        .i_divisor  (r_den),
        .o_res      (w_div)
    );

    // checks
    `PSI_ASSERT_NOW(a_count_bound, 1'b1, r_cnt <= CNT_MAX, "point count above table depth")
    `PSI_ASSERT_NEXT(a_full_flag, w_accept && (i_in.cmd == psi_pkg::CMD_APPEND) && w_full, o_out.valid && o_out.table_full && (r_cnt == CNT_MAX), "append to full table not flagged")
    `PSI_ASSERT_NEXT(a_clear_count, w_accept && (i_in.cmd == psi_pkg::CMD_CLEAR), r_cnt == '0, "clear did not empty the table")
    `PSI_ASSERT_NOW(a_mul_in_state, w_mul_done, r_state == S_MUL, "multiplier finished outside multiply phase")
endmodule

[verif/psi_setpoint_checker.sv]
// -----------------------------------------------------------------------------
// psi_setpoint_checker
// watches the command and result channels of the setpoint interpolator,
// keeps its own copy of the profile table and registers, predicts every
// result and compares it field by field in arrival order
// -----------------------------------------------------------------------------
module psi_setpoint_checker
    import psi_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    psi_in_if                     in_ch,
    psi_out_if                    out_ch,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [TEMP_W-1:0] setpoint;
        logic              done_res;
        logic              table_full;
    } t_psi_result;

    logic [TIME_W-1:0] max_time;
    logic [TEMP_W-1:0] manual_temp;
    logic [TIME_W-1:0] point_time [TABLE_DEPTH];
    logic [TEMP_W-1:0] point_temp [TABLE_DEPTH];
    int unsigned       point_count;

    t_psi_result awaited_results[$];
    int          mismatches;
    int          checked;

    // setpoint at elapsed time t from the stored profile points
    function automatic logic [TEMP_W-1:0] interp_setpoint(input logic [TIME_W-1:0] t);
        int unsigned idx;
        longint      x1, y1, x2, y2, num, den, q;
        idx = 0;
        x1  = 0;
        y1  = 0;
        if (point_count == 0)
            return manual_temp;
        while (idx < point_count && point_time[idx] <= t)
            idx++;
        if (idx == point_count)
            return point_temp[point_count-1];
        if (idx > 0) begin
            x1 = point_time[idx-1];
            y1 = point_temp[idx-1];
        end
        x2  = point_time[idx];
        y2  = point_temp[idx];
        den = x2 - x1;
        if (den <= 0)
            return TEMP_W'(y1);
        num = (y2 - y1) * (longint'(t) - x1);
        // floor toward minus infinity on falling segments
        if (num >= 0)
            q = num / den;
        else
            q = -((-num + den - 1) / den);
        return TEMP_W'(y1 + q);
    endfunction

    function automatic t_psi_result apply_command(input t_cmd c,
                                                  input logic [TIME_W-1:0] t,
                                                  input logic [TEMP_W-1:0] d);
        t_psi_result res;
        res = '0;
        case (c)
            CMD_CLEAR: begin
                point_count = 0;
            end
            CMD_APPEND: begin
                if (point_count >= TABLE_DEPTH) begin
                    res.table_full = 1'b1;
                end else begin
                    point_time[point_count] = t;
                    point_temp[point_count] = d;
                    point_count++;
                end
            end
            CMD_QUERY: begin
                res.setpoint = interp_setpoint(t);
                res.done_res = (t > max_time);
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic compare_result(input t_psi_result got);
        t_psi_result want;
        if (awaited_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("[%0t] result with none awaited: setpoint %0d done %0b full %0b",
                         $realtime, got.setpoint, got.done_res, got.table_full);
        end else begin
            want = awaited_results.pop_front();
            checked++;
            if (got.setpoint !== want.setpoint || got.done_res !== want.done_res ||
                got.table_full !== want.table_full) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("[%0t] mismatch: expected setpoint %0d done %0b full %0b, got %0d %0b %0b",
                             $realtime, want.setpoint, want.done_res, want.table_full,
                             got.setpoint, got.done_res, got.table_full);
            end
        end
    endtask

    initial begin
        mismatches   = 0;
        checked      = 0;
        point_count  = 0;
        max_time     = MAX_TIME_RST;
        manual_temp  = MANUAL_TEMP_RST;
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            point_count = 0;
            max_time    = MAX_TIME_RST;
            manual_temp = MANUAL_TEMP_RST;
            awaited_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_TIME:    max_time    = i_cfg_data[TIME_W-1:0];
                    CFG_MANUAL_TEMP: manual_temp = i_cfg_data[TEMP_W-1:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                awaited_results.push_back(apply_command(in_ch.cmd, in_ch.time_s,
                                                        in_ch.temp_deg));
            if (out_ch.valid && out_ch.ready)
                compare_result({out_ch.setpoint, out_ch.done_res, out_ch.table_full});
        end
        o_fail_count <= mismatches;
        o_pending    <= awaited_results.size();
        o_checked    <= checked;
    end

endmodule

[verif/testbench.sv]
// -----------------------------------------------------------------------------
// testbench
// drives command transactions into the profile setpoint interpolator:
// a short directed list of corner cases, then random profiles (clear,
// append points, query) mixed with random noise commands, over four
// flow-control phases and several register settings; the checker beside
// the block predicts and compares every result
// -----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import psi_pkg::*;

    localparam int   TABLE_DEPTH     = 16;
    localparam int   ITEMS_PER_BLOCK = 125;   // 4 phases x 3 settings ~ 1500 items
    localparam int   SETTINGS_PER_PH = 3;
    localparam int   CYCLE_LIMIT     = 1_000_000;
    localparam int   SETTLE_CYCLES   = 4;     // every command returns a result
    localparam int   TAIL_CYCLES     = 80;    // about one full-table query
    localparam int   MAX_GAP         = 20;
    localparam t_cmd CMD_UNUSED      = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int checked;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;
    int items_sent;
    int cmd_tally [4];
    int settings_used;

    psi_in_if  cmd_ch ();
    psi_out_if res_ch ();

    profile_setpoint_interpolator_unit #(
        .MAX_POINTS (TABLE_DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (cmd_ch),
        .o_out      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    psi_setpoint_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .in_ch        (cmd_ch),
        .out_ch       (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 12 ns clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog: a hung handshake ends the run as a failure
    initial cycle_count = 0;
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still awaited",
                     cycle_count, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: ready toggles at random with the current stall rate
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // one command transaction; an optional idle gap goes in front of it,
    // and valid stays high when the next transaction follows without a gap
    task automatic send_cmd(input t_cmd c, input logic [TIME_W-1:0] t,
                            input logic [TEMP_W-1:0] d);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.cmd      <= c;
        cmd_ch.time_s   <= t;
        cmd_ch.temp_deg <= d;
        do @(posedge clk); while (!cmd_ch.ready);
        cmd_tally[c]++;
        // unused codes leave the block's state alone and do not count as items
        if (c != CMD_UNUSED)
            items_sent++;
    endtask

    // stop sending and wait until every awaited result has been checked
    task automatic drain(input int settle);
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // both registers back to back, only while the block is idle
    task automatic write_regs(input logic [TIME_W-1:0] max_t, input logic [TEMP_W-1:0] manual);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_MAX_TIME;
        cfg_data <= max_t;
        @(negedge clk);
        cfg_idx  <= CFG_MANUAL_TEMP;
        cfg_data <= CFG_DATA_W'(manual);
        @(negedge clk);
        cfg_we   <= 1'b0;
        settings_used++;
    endtask

    initial begin
        int          phase;
        int          setting;
        int          block_goal;
        int          n_pts;
        int          n_queries;
        int          k;
        int          t;
        int          last_t;
        int          span;
        logic [11:0] max_t;
        logic [8:0]  manual;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_MAX_TIME;
        cfg_data        = '0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.cmd      = CMD_CLEAR;
        cmd_ch.time_s   = '0;
        cmd_ch.temp_deg = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        items_sent      = 0;
        settings_used   = 0;
        foreach (cmd_tally[i]) cmd_tally[i] = 0;

        // reset held low at the start, then released once
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---------------------------------------------------------------
        // directed part, reset settings (max_time 900, manual 50)
        // ---------------------------------------------------------------
        // empty table returns the manual temperature; done just past max_time
        send_cmd(CMD_QUERY, 12'd0, 9'd0);
        send_cmd(CMD_QUERY, 12'hFFF, 9'h1FF);
        send_cmd(CMD_QUERY, MAX_TIME_RST, 9'd0);
        send_cmd(CMD_QUERY, MAX_TIME_RST + 12'd1, 9'd0);
        // unused code leaves everything alone and returns zeros
        send_cmd(CMD_UNUSED, 12'hFFF, 9'h1FF);
        // points out of time order, with a falling segment to 0 degrees
        send_cmd(CMD_APPEND, 12'd100, 9'd200);
        send_cmd(CMD_APPEND, 12'd50, 9'd511);
        send_cmd(CMD_APPEND, 12'd300, 9'd0);
        send_cmd(CMD_QUERY, 12'd30, 9'd0);      // rising from the origin
        send_cmd(CMD_QUERY, 12'd100, 9'd0);     // falling segment, floor
        send_cmd(CMD_QUERY, 12'd299, 9'd0);
        send_cmd(CMD_QUERY, 12'd300, 9'd0);     // past the last point
        send_cmd(CMD_QUERY, 12'hFFF, 9'd0);
        // clear ignores its fields, then back to manual
        send_cmd(CMD_CLEAR, 12'hFFF, 9'h1FF);
        send_cmd(CMD_QUERY, 12'd10, 9'd0);
        // single point at the far corner
        send_cmd(CMD_APPEND, 12'hFFF, 9'h1FF);
        send_cmd(CMD_QUERY, 12'd0, 9'd0);
        send_cmd(CMD_QUERY, 12'hFFE, 9'd0);
        send_cmd(CMD_QUERY, 12'hFFF, 9'd0);

        // lowest register values
        drain(SETTLE_CYCLES);
        write_regs(12'd0, 9'd0);
        send_cmd(CMD_CLEAR, 12'd0, 9'd0);
        send_cmd(CMD_QUERY, 12'd0, 9'd0);
        send_cmd(CMD_QUERY, 12'd1, 9'd0);

        // highest register values
        drain(SETTLE_CYCLES);
        write_regs(12'hFFF, 9'h1FF);
        send_cmd(CMD_QUERY, 12'hFFF, 9'd0);

        // ---------------------------------------------------------------
        // random part: no idling, sender idle, receiver stalling, both
        // ---------------------------------------------------------------
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 59; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 59; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            for (setting = 0; setting < SETTINGS_PER_PH; setting++) begin
                // new register setting, extremes picked often
                case ($urandom_range(0, 3))
                    0:       max_t = 12'd0;
                    1:       max_t = 12'hFFF;
                    default: max_t = 12'($urandom_range(0, 4095));
                endcase
                case ($urandom_range(0, 3))
                    0:       manual = 9'd0;
                    1:       manual = 9'h1FF;
                    default: manual = 9'($urandom_range(0, 511));
                endcase
                drain(SETTLE_CYCLES);
                write_regs(max_t, manual);

                block_goal = items_sent + ITEMS_PER_BLOCK;
                while (items_sent < block_goal) begin
                    if ($urandom_range(0, 99) < 80) begin
                        // well-formed profile: clear, points, then queries
                        send_cmd(CMD_CLEAR, 12'($urandom_range(0, 4095)),
                                 9'($urandom_range(0, 511)));
                        // now and then overfill to hit the rejected append
                        if ($urandom_range(0, 99) < 15)
                            n_pts = $urandom_range(TABLE_DEPTH, TABLE_DEPTH + 4);
                        else
                            n_pts = $urandom_range(0, 12);
                        last_t = $urandom_range(0, 400);
                        span   = $urandom_range(1, 600);
                        for (k = 0; k < n_pts; k++) begin
                            // mostly ascending times, some out of order
                            if ($urandom_range(0, 9) == 0) begin
                                t = $urandom_range(0, 4095);
                            end else begin
                                t = last_t;
                                last_t = last_t + $urandom_range(1, span);
                                if (last_t > 4095)
                                    last_t = 4095;
                            end
                            send_cmd(CMD_APPEND, 12'(t), 9'($urandom_range(0, 511)));
                        end
                        n_queries = $urandom_range(2, 8);
                        for (k = 0; k < n_queries; k++) begin
                            if ($urandom_range(0, 9) < 7)
                                t = $urandom_range(0, (last_t + 100 > 4095) ? 4095 : last_t + 100);
                            else
                                t = $urandom_range(0, 4095);
                            send_cmd(CMD_QUERY, 12'(t), 9'($urandom_range(0, 511)));
                        end
                    end else begin
                        // noise: any code, any field values
                        send_cmd(t_cmd'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)),
                                 9'($urandom_range(0, 511)));
                    end
                    // sender holds off until the block has emptied
                    if ($urandom_range(0, 99) < 3)
                        drain(0);
                end
            end
        end

        // wait out every awaited result plus one long query
        drain(TAIL_CYCLES);

        $display("sent %0d clears, %0d appends, %0d queries, %0d unused codes",
                 cmd_tally[CMD_CLEAR], cmd_tally[CMD_APPEND], cmd_tally[CMD_QUERY],
                 cmd_tally[CMD_UNUSED]);
        $display("%0d register settings, %0d results checked, %0d mismatches",
                 settings_used, checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
